// ----- hw/rtl/bole_pkg.sv -----
// Shared types and constants of the bounded ordered list engine.
package bole_pkg;

  localparam int unsigned CapacityDef = 32;
  localparam int unsigned ValW        = 32;
  localparam int unsigned LenW        = 6;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_MID  = 3'd2,
    CMD_REMOVE   = 3'd3,
    CMD_COUNT    = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_LOAD   = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     valid;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/bole_cell.sv -----
// One list slot: holds an element, compares it, takes a neighbor's value on shifts.
module bole_cell (
  input  logic                       clk_i,
  input  bole_pkg::cell_ctrl_t       ctrl_i,
  input  logic [bole_pkg::ValW-1:0]  left_i,
  input  logic [bole_pkg::ValW-1:0]  right_i,
  input  logic [bole_pkg::ValW-1:0]  new_i,
  input  logic [bole_pkg::ValW-1:0]  key_i,
  input  logic                       found_i,
  output logic                       found_o,
  output logic [bole_pkg::ValW-1:0]  data_o
);
  import bole_pkg::*;

  logic [ValW-1:0] data_q, data_d;

  // a match here or in any slot nearer the head
  assign found_o = found_i | (ctrl_i.valid && (data_q == key_i));

  always_comb begin
    unique case (ctrl_i.op)
      CELL_SHIFT:  data_d = left_i;
      CELL_LOAD:   data_d = new_i;
      CELL_REMOVE: data_d = found_o ? right_i : data_q;
      default:     data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine: command decode, slot chain, result register.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit values in a
// row of slot cells, head in cell 0. Each command transfer on the slave side
// (cmd in s_tuser, value in s_tdata) yields exactly one result transfer on the
// master side (status in m_tuser, removed value and length in m_tdata). All
// cells act together: inserts shift all cells behind the insert
// point one place toward the tail in parallel, a remove compares all valid
// cells at once, a found-chain through the row marks the first match, and
// every cell at or behind it takes its tail-side neighbor. The result sits in
// an output register; a new command is taken whenever that register is empty
// or is being drained in the same cycle, so back-to-back commands run at one
// per clock. A middle insert lands at index length/2 (index 1 for a single
// element list); an insert into an empty list stores the only element; a full
// list rejects inserts with status full; a remove reports not-found or empty.
// Length is reported modulo 64, so a full list at CAPACITY 64 reads 0.
module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY = bole_pkg::CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic [2:0]  s_tuser_i,   // [2:0] cmd
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [31:0] removed_value, [37:32] length, [39:38] zero
  output logic [1:0]  m_tuser_o    // [1:0] status
);
  import bole_pkg::*;

  localparam int unsigned OccW = $clog2(CAPACITY + 1);

  logic            accept;
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] pos;
  logic            full, empty;
  logic            do_insert, do_remove;
  logic            found;
  cmd_e            cmd;
  logic [ValW-1:0] value;

  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [ValW-1:0] removed_q, removed_d;
  logic [LenW-1:0] length_q;
  logic [OccW+LenW-1:0] occ_ext;

  logic [ValW-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0] found_chain;

  assign cmd    = cmd_e'(s_tuser_i);
  assign value  = s_tdata_i;
  assign accept = s_tvalid_i && s_tready_o;
  assign full   = (occ_q == OccW'(CAPACITY));
  assign empty  = (occ_q == '0);

  // hold a new command off only while an untaken result blocks the register
  assign s_tready_o = !out_valid_q || m_tready_i;

  // insert point
  always_comb begin
    unique case (cmd)
      CMD_INS_HEAD: pos = '0;
      CMD_INS_TAIL: pos = occ_q;
      CMD_INS_MID:  pos = (occ_q == OccW'(1)) ? OccW'(1) : (occ_q >> 1);
      default:      pos = '0;
    endcase
  end

  assign do_insert = accept && !full &&
                     (cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL || cmd == CMD_INS_MID);
  assign do_remove = accept && !empty && (cmd == CMD_REMOVE);

  // slot chain: the found flag ripples from head to tail
  assign found_chain[0] = 1'b0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    cell_ctrl_t      ctrl;
    logic [ValW-1:0] left_val, right_val;

    always_comb begin
      ctrl.valid = (OccW'(k) < occ_q);
      if (do_insert && (OccW'(k) > pos)) begin
        ctrl.op = CELL_SHIFT;
      end else if (do_insert && (OccW'(k) == pos)) begin
        ctrl.op = CELL_LOAD;
      end else if (do_remove) begin
        ctrl.op = CELL_REMOVE;
      end else begin
        ctrl.op = CELL_HOLD;
      end
    end

    if (k == 0) begin : g_head
      assign left_val = value;
    end else begin : g_body
      assign left_val = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_data[k+1];
    end

    bole_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_val),
      .right_i (right_val),
      .new_i   (value),
      .key_i   (value),
      .found_i (found_chain[k]),
      .found_o (found_chain[k+1]),
      .data_o  (cell_data[k])
    );
  end

  assign found = found_chain[CAPACITY];

  // occupancy and result
  always_comb begin
    occ_d     = occ_q;
    status_d  = ST_OK;
    removed_d = '0;
    unique case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_MID: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          occ_d = occ_q + OccW'(1);
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          occ_d     = occ_q - OccW'(1);
          removed_d = value;
        end
      end
      CMD_CLEAR: occ_d = '0;
      default:   occ_d = occ_q;
    endcase
  end

  assign occ_ext = (OccW + LenW)'(occ_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      length_q  <= occ_ext[LenW-1:0];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = status_q;
  assign m_tdata_o  = {2'b00, length_q, removed_q};

endmodule

// ----- tb/bounded_ordered_list_engine_tb.sv -----
// Testbench of the bounded ordered list engine: directed and random command streams.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam int unsigned Cap        = CapacityDef;
  localparam int          StallLimit = 2000;  // cycles with no transfer on either side
  localparam int          DrainCycles = 10;
  localparam int          MaxPrinted = 40;

  // Codes 6 and 7 are not commands; the engine must leave the list alone.
  localparam logic [2:0]  CmdRsvdLo = 3'd6;
  localparam logic [2:0]  CmdRsvdHi = 3'd7;

  localparam logic [31:0] ValMin = 32'h8000_0000;
  localparam logic [31:0] ValMax = 32'h7FFF_FFFF;

  typedef struct packed {
    status_e     status;
    logic [31:0] removed;
    logic [5:0]  length;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_tready_o;
  logic        m_tvalid_o;
  logic [39:0] m_tdata_o;
  logic [1:0]  m_tuser_o;

  // Shadow copy of the list, head at index 0.
  logic [31:0] list_mem [Cap];
  int          list_len = 0;

  list_result_t pending_results[$];
  int           mismatch_cnt = 0;
  int           send_idle_pct = 0;
  int           rcv_stall_pct = 0;
  int           quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bounded_ordered_list_engine #(
    .CAPACITY(Cap)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata),
    .s_tuser_i (s_tuser),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

  // Apply one command to the shadow list and return the result it must produce.
  function automatic list_result_t apply_list_cmd(input logic [2:0] cmd,
                                                  input logic [31:0] val);
    list_result_t res;
    int           pos;
    int           k;
    int           hit;
    res.status  = ST_OK;
    res.removed = '0;
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_MID: begin
        if (list_len >= Cap) begin
          res.status = ST_FULL;
        end else begin
          // a middle insert into one element goes behind it, otherwise at len/2
          if (cmd == CMD_INS_HEAD) pos = 0;
          else if (cmd == CMD_INS_TAIL || list_len == 1) pos = list_len;
          else pos = list_len / 2;
          for (k = list_len; k > pos; k--) list_mem[k] = list_mem[k-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (k = 0; k < list_len; k++) begin
            if (hit < 0 && list_mem[k] == val) hit = k;
          end
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (k = hit; k < list_len - 1; k++) list_mem[k] = list_mem[k+1];
            list_len--;
            res.removed = val;
          end
        end
      end
      CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    res.length = 6'(list_len);
    return res;
  endfunction

  // Mostly small values so that duplicates occur, some extremes, some full range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return ($urandom_range(1)) ? ValMin : ValMax;
      default: return 32'($urandom_range(15)) - 32'd8;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted)
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Offer one command, hold it until the transfer, then record its expected result.
  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready_o) @(posedge clk);
    pending_results.push_back(apply_list_cmd(cmd, val));
  endtask

  // Empty-list behavior of every command but clear, extremes, duplicates, ignored codes.
  task automatic test_directed();
    send_cmd(CMD_REMOVE, 32'd5);       // remove from an empty list
    send_cmd(CMD_COUNT, ValMax);
    send_cmd(CmdRsvdLo, 32'd9);
    send_cmd(CmdRsvdHi, 32'hFFFF_FFFF);
    send_cmd(CMD_INS_MID, ValMax);     // middle insert into an empty list
    send_cmd(CMD_INS_MID, ValMin);     // middle insert behind a single element
    send_cmd(CMD_CLEAR, 32'd0);
    send_cmd(CMD_INS_HEAD, 32'd0);     // head insert into an empty list
    send_cmd(CMD_CLEAR, ValMin);
    send_cmd(CMD_INS_TAIL, 32'hFFFF_FFFF);  // tail insert into an empty list
    send_cmd(CMD_INS_HEAD, ValMin);
    send_cmd(CMD_INS_TAIL, ValMax);
    send_cmd(CMD_INS_MID, 32'd42);
    send_cmd(CMD_INS_MID, 32'd42);
    send_cmd(CMD_REMOVE, 32'd1234);    // absent value
    send_cmd(CMD_REMOVE, 32'd42);      // first of two equal values
    send_cmd(CMD_REMOVE, ValMin);      // head
    send_cmd(CMD_REMOVE, ValMax);      // tail
    send_cmd(CMD_COUNT, 32'd0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
    send_cmd(CMD_REMOVE, 32'd42);      // last element
    send_cmd(CMD_REMOVE, 32'd42);
  endtask

  // Fill to capacity, reject inserts of every kind, reshuffle, drain by value.
  task automatic test_full_list();
    while (list_len < Cap) send_cmd(3'($urandom_range(2)), pick_value());
    send_cmd(CMD_INS_HEAD, pick_value());
    send_cmd(CMD_INS_TAIL, pick_value());
    send_cmd(CMD_INS_MID, pick_value());
    send_cmd(CMD_COUNT, $urandom());
    send_cmd(CMD_REMOVE, list_mem[Cap/2]);
    send_cmd(CMD_INS_MID, pick_value());
    send_cmd(CMD_REMOVE, list_mem[Cap-1]);
    send_cmd(CMD_INS_TAIL, pick_value());
    send_cmd(CMD_REMOVE, list_mem[0]);
    send_cmd(CMD_INS_HEAD, pick_value());
    while (list_len > 0) send_cmd(CMD_REMOVE, list_mem[$urandom_range(list_len - 1)]);
    send_cmd(CMD_REMOVE, pick_value());
  endtask

  // Random mix that swings the list between nearly empty and full.
  task automatic test_random(input int n_items);
    bit          filling;
    int          r;
    logic [31:0] val;
    filling = 1'b1;
    repeat (n_items) begin
      if (list_len >= Cap) filling = 1'b0;
      else if (list_len <= 2) filling = 1'b1;
      r   = $urandom_range(99);
      val = pick_value();
      if (r < (filling ? 65 : 25)) begin
        send_cmd(3'($urandom_range(2)), val);
      end else if (r < 80) begin
        // mostly remove something that is held
        if (list_len > 0 && $urandom_range(3) != 0)
          val = list_mem[$urandom_range(list_len - 1)];
        send_cmd(CMD_REMOVE, val);
      end else if (r < 88) begin
        send_cmd(CMD_REMOVE, $urandom());
      end else if (r < 94) begin
        send_cmd(CMD_COUNT, $urandom());
      end else if (r < 96) begin
        send_cmd(CMD_CLEAR, $urandom());
      end else begin
        send_cmd(3'($urandom_range(6, 7)), $urandom());
      end
    end
  endtask

  // Receiver side: stall at random at the current rate.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Compare every result transfer with the oldest pending expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && m_tvalid_o && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser_o !== want.status)
          report_mismatch("status", 40'(m_tuser_o), 40'(want.status));
        if (m_tdata_o[31:0] !== want.removed)
          report_mismatch("removed_value", 40'(m_tdata_o[31:0]), 40'(want.removed));
        if (m_tdata_o[37:32] !== want.length)
          report_mismatch("length", 40'(m_tdata_o[37:32]), 40'(want.length));
      end
    end
  end

  // Abort when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender rarely idle, receiver often stalled
    send_idle_pct = 7;
    rcv_stall_pct = 58;
    test_directed();
    test_full_list();
    test_random(150);

    // the other way round
    send_idle_pct = 58;
    rcv_stall_pct = 7;
    test_random(150);

    // full rate on both sides
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    test_random(150);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results left over", 40'(pending_results.size()), '0);

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
